### sv/i2cees_pkg.sv
package i2cees_pkg;

    // Depth of the write payload store
    localparam int PAYLOAD_DEPTH = 16;
    localparam int PAW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int PCW0 = $clog2(PAYLOAD_DEPTH + 1);
    // Position counter also walks the read bytes (up to 16), so keep at least 5 bits
    localparam int PCW  = (PCW0 > 5) ? PCW0 : 5;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_LOAD  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_TX      = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5
    } t_cmd;

    // Engine status codes, divided by eight
    localparam logic [4:0] ST_START    = 5'd1;   // 0x08
    localparam logic [4:0] ST_RESTART  = 5'd2;   // 0x10
    localparam logic [4:0] ST_SLAW_ACK = 5'd3;   // 0x18
    localparam logic [4:0] ST_DATA_ACK = 5'd5;   // 0x28
    localparam logic [4:0] ST_SLAR_ACK = 5'd8;   // 0x40
    localparam logic [4:0] ST_RX_ACK   = 5'd10;  // 0x50
    localparam logic [4:0] ST_RX_NACK  = 5'd11;  // 0x58

    localparam logic CFG_DEVICE_SELECT = 1'b0;
    localparam logic CFG_READ_COUNT    = 1'b1;

    localparam logic [6:0] DEVICE_SELECT_RESET = 7'd80;
    localparam logic [4:0] READ_COUNT_RESET    = 5'd10;
    localparam logic [4:0] READ_COUNT_MAX      = 5'd16;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [3:0] rx_index;
        logic       done;
        logic       success;
    } t_result;

    typedef struct packed {
        logic           en;
        logic [PAW-1:0] addr;
        logic [7:0]     data;
    } t_ram_wr;

endpackage

### sv/i2cees_ram.sv
module i2cees_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/i2cees_ctrl.sv
module i2cees_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_kind,
    input  logic [15:0]                i_mem_address,
    input  logic [7:0]                 i_payload_byte,
    input  logic                       i_payload_last,
    input  logic [4:0]                 i_bus_status,
    input  logic [7:0]                 i_rx_byte,
    input  logic [6:0]                 i_device_select,
    input  logic [4:0]                 i_read_count,
    input  logic [7:0]                 i_ram_rdata,
    output i2cees_pkg::t_ram_wr        o_ram_wr,
    output logic [i2cees_pkg::PAW-1:0] o_ram_raddr,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output i2cees_pkg::t_result        o_result
);
    import i2cees_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_SLAW, PH_RETRY, PH_ADDR_HI,
        PH_ADDR_LO, PH_DATA, PH_RESTART, PH_SLAR, PH_RX
    } t_phase;

    t_phase         r_phase, n_phase;
    logic           r_is_read, n_is_read;
    logic [15:0]    r_taddr, n_taddr;
    logic [PCW-1:0] r_len, n_len;
    logic [PCW-1:0] r_pos, n_pos;
    logic           r_out_valid;
    t_result        r_result;

    t_result        res;
    logic           has_res;
    logic           accept;
    logic [4:0]     eff_count;
    logic [PCW-1:0] eff_ext;
    logic [PCW-1:0] pos_ld;
    logic [PCW-1:0] pos_data;
    logic           rx_last;
    logic           rx_next_last;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // Clamp the live read count to 1..16
    always_comb begin
        priority if (i_read_count == 5'd0) begin
            eff_count = 5'd1;
        end else if (i_read_count > READ_COUNT_MAX) begin
            eff_count = READ_COUNT_MAX;
        end else begin
            eff_count = i_read_count;
        end
    end

    assign eff_ext      = PCW'(eff_count);
    assign rx_last      = (r_pos + PCW'(1)) >= eff_ext;
    assign rx_next_last = (r_pos + PCW'(2)) >= eff_ext;
    assign pos_ld       = (r_pos < PCW'(PAYLOAD_DEPTH)) ? r_pos + PCW'(1) : r_pos;
    assign pos_data     = (r_phase == PH_ADDR_LO) ? '0 : r_pos;

    always_comb begin
        n_phase   = r_phase;
        n_is_read = r_is_read;
        n_taddr   = r_taddr;
        n_len     = r_len;
        n_pos     = r_pos;
        res       = '0;
        has_res   = 1'b0;
        o_ram_wr  = '0;

        if (accept) begin
            unique case (t_kind'(i_kind))
                KIND_LOAD: begin
                    if (r_phase == PH_IDLE) begin
                        o_ram_wr.en   = r_pos < PCW'(PAYLOAD_DEPTH);
                        o_ram_wr.addr = r_pos[PAW-1:0];
                        o_ram_wr.data = i_payload_byte;
                        n_pos         = pos_ld;
                        if (i_payload_last) begin
                            n_len = pos_ld;
                            n_pos = '0;
                        end
                    end
                end
                KIND_READ, KIND_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read = (t_kind'(i_kind) == KIND_READ);
                        n_taddr   = i_mem_address;
                        n_pos     = '0;
                        n_phase   = PH_START;
                        has_res   = 1'b1;
                        res.cmd   = CMD_START;
                    end
                end
                KIND_EVENT: begin
                    has_res = (r_phase != PH_IDLE);
                    unique case (r_phase)
                        PH_IDLE: begin
                        end
                        PH_START, PH_RETRY: begin
                            if (i_bus_status == ST_START ||
                                (r_phase == PH_RETRY && i_bus_status == ST_RESTART)) begin
                                n_phase     = PH_SLAW;
                                res.cmd     = CMD_TX;
                                res.tx_byte = {i_device_select, 1'b0};
                            end else begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end
                        end
                        PH_SLAW: begin
                            if (i_bus_status == ST_SLAW_ACK) begin
                                n_phase     = PH_ADDR_HI;
                                res.cmd     = CMD_TX;
                                res.tx_byte = r_taddr[15:8];
                            end else begin
                                // no acknowledge: start again
                                n_phase = PH_RETRY;
                                res.cmd = CMD_START;
                            end
                        end
                        PH_ADDR_HI: begin
                            if (i_bus_status == ST_DATA_ACK) begin
                                n_phase     = PH_ADDR_LO;
                                res.cmd     = CMD_TX;
                                res.tx_byte = r_taddr[7:0];
                            end else begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end
                        end
                        PH_ADDR_LO, PH_DATA: begin
                            if (i_bus_status != ST_DATA_ACK) begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end else if (r_phase == PH_ADDR_LO && r_is_read) begin
                                n_phase = PH_RESTART;
                                res.cmd = CMD_START;
                            end else if (pos_data < r_len &&
                                         pos_data < PCW'(PAYLOAD_DEPTH)) begin
                                // read data already holds the entry at pos_data
                                n_phase     = PH_DATA;
                                res.cmd     = CMD_TX;
                                res.tx_byte = i_ram_rdata;
                                n_pos       = pos_data + PCW'(1);
                            end else begin
                                n_phase     = PH_IDLE;
                                n_pos       = '0;
                                res.cmd     = CMD_STOP;
                                res.done    = 1'b1;
                                res.success = 1'b1;
                            end
                        end
                        PH_RESTART: begin
                            if (i_bus_status == ST_RESTART) begin
                                n_phase     = PH_SLAR;
                                res.cmd     = CMD_TX;
                                res.tx_byte = {i_device_select, 1'b1};
                            end else begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end
                        end
                        PH_SLAR: begin
                            if (i_bus_status == ST_SLAR_ACK) begin
                                n_phase = PH_RX;
                                n_pos   = '0;
                                res.cmd = (eff_count == 5'd1) ? CMD_RX_NACK : CMD_RX_ACK;
                            end else begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end
                        end
                        PH_RX: begin
                            if (rx_last && i_bus_status == ST_RX_NACK) begin
                                n_phase      = PH_IDLE;
                                n_pos        = '0;
                                res.cmd      = CMD_STOP;
                                res.rx_valid = 1'b1;
                                res.rx_data  = i_rx_byte;
                                res.rx_index = r_pos[3:0];
                                res.done     = 1'b1;
                                res.success  = 1'b1;
                            end else if (!rx_last && i_bus_status == ST_RX_ACK) begin
                                n_pos        = r_pos + PCW'(1);
                                res.cmd      = rx_next_last ? CMD_RX_NACK : CMD_RX_ACK;
                                res.rx_valid = 1'b1;
                                res.rx_data  = i_rx_byte;
                                res.rx_index = r_pos[3:0];
                            end else begin
                                n_phase  = PH_IDLE;
                                n_pos    = '0;
                                res.done = 1'b1;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // Prefetch the entry at the next position so it is ready for the next event
    assign o_ram_raddr = n_pos[PAW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_is_read   <= 1'b0;
            r_taddr     <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_is_read <= n_is_read;
            r_taddr   <= n_taddr;
            r_len     <= n_len;
            r_pos     <= n_pos;
            if (accept && has_res) begin
                r_out_valid <= 1'b1;
                r_result    <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### sv/i2c_eeprom_transaction_sequencer.sv
// Master-side sequencer for an I2C EEPROM, driving a byte-level I2C engine.
//
// Input channel (i_in_valid / o_in_stall): one item per cycle. An item is a
// request (read or write at i_mem_address), a payload byte load, or a bus
// event carrying the engine status and received byte.
// Output channel (o_out_valid / i_out_stall): zero or one result per item,
// giving the next engine command, the read byte and the end-of-transaction
// flags. A result appears in the cycle after its item is accepted.
// Throughput is one item per cycle; a payload byte goes out of the 16-entry
// store, whose next entry is always prefetched so a data event finds it
// waiting in the RAM read register.
// When the receiver stalls, the result holds in the output register and a
// further item is stalled only while that register is still full.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 device
// select, index 1 read count. Write only while no transaction is running.
// Reset: synchronous, active low; control state returns to idle, device
// select 80, read count 10. The payload store has no reset and needs no
// clearing pass: only loaded bytes are ever sent.
module i2c_eeprom_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_mem_address,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_payload_last,
    input  logic [4:0]  i_bus_status,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_command,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_data,
    output logic [3:0]  o_rx_index,
    output logic        o_done_res,
    output logic        o_success,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import i2cees_pkg::*;

    logic [6:0]     r_device_select;
    logic [4:0]     r_read_count;
    t_ram_wr        ram_wr;
    logic [PAW-1:0] ram_raddr;
    logic [7:0]     ram_rdata;
    t_result        result;

    assign o_cfg_ready = 1'b1;

    // Hold the two configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_select <= DEVICE_SELECT_RESET;
            r_read_count    <= READ_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEVICE_SELECT: r_device_select <= i_cfg_data;
                CFG_READ_COUNT:    r_read_count    <= i_cfg_data[4:0];
            endcase
        end
    end

    // Payload store: one write port for loads, one prefetching read port
    i2cees_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.en),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    i2cees_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_mem_address   (i_mem_address),
        .i_payload_byte  (i_payload_byte),
        .i_payload_last  (i_payload_last),
        .i_bus_status    (i_bus_status),
        .i_rx_byte       (i_rx_byte),
        .i_device_select (r_device_select),
        .i_read_count    (r_read_count),
        .i_ram_rdata     (ram_rdata),
        .o_ram_wr        (ram_wr),
        .o_ram_raddr     (ram_raddr),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (result)
    );

    assign o_command  = result.cmd;
    assign o_tx_byte  = result.tx_byte;
    assign o_rx_valid = result.rx_valid;
    assign o_rx_data  = result.rx_data;
    assign o_rx_index = result.rx_index;
    assign o_done_res = result.done;
    assign o_success  = result.success;

endmodule

### sv/i2cees_chk.sv
module i2cees_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_command,
    input logic [7:0]  o_tx_byte,
    input logic        o_rx_valid,
    input logic        o_done_res,
    input logic        o_success
);
    import i2cees_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_command) && $stable(o_tx_byte))
        else $error("stalled result dropped or changed");

    a_success_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_success |-> o_done_res && o_command == CMD_STOP)
        else $error("success without a closing stop");

    a_rx_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rx_valid |->
            o_command == CMD_RX_ACK || o_command == CMD_RX_NACK || o_command == CMD_STOP)
        else $error("read byte delivered with a non-receive command");

endmodule

bind i2c_eeprom_transaction_sequencer i2cees_chk u_chk (.*);

### verif/i2c_eeprom_transaction_sequencer_tb.sv
module i2c_eeprom_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cees_pkg::*;

    // Cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Random items per idling phase, eight phases in all
    localparam int ITEMS_PER_PHASE = 115;
    // Status an engine returns when SLA+W is not acknowledged (0x20)
    localparam logic [4:0] ST_SLAW_NACK = 5'd4;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_START, SEQ_SLAW, SEQ_RETRY, SEQ_ADDR_HI,
        SEQ_ADDR_LO, SEQ_DATA, SEQ_RESTART, SEQ_SLAR, SEQ_RX
    } t_seq_phase;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] mem_address;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [4:0]  bus_status;
        logic [7:0]  rx_byte;
    } t_item;

    // Where the expectation for a directed row comes from
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} t_exp_src;
    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op    op;
        t_item      item;
        t_exp_src   src;
        t_result    res;
        logic       cfg_index;
        logic [6:0] cfg_value;
    } t_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_kind         = '0;
    logic [15:0] i_mem_address  = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        i_payload_last = 1'b0;
    logic [4:0]  i_bus_status   = '0;
    logic [7:0]  i_rx_byte      = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        i_cfg_index    = 1'b0;
    logic [6:0]  i_cfg_data     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_command;
    logic [7:0]  o_tx_byte;
    logic        o_rx_valid;
    logic [7:0]  o_rx_data;
    logic [3:0]  o_rx_index;
    logic        o_done_res;
    logic        o_success;
    logic        o_cfg_ready;

    i2c_eeprom_transaction_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_mem_address  (i_mem_address),
        .i_payload_byte (i_payload_byte),
        .i_payload_last (i_payload_last),
        .i_bus_status   (i_bus_status),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command      (o_command),
        .o_tx_byte      (o_tx_byte),
        .o_rx_valid     (o_rx_valid),
        .o_rx_data      (o_rx_data),
        .o_rx_index     (o_rx_index),
        .o_done_res     (o_done_res),
        .o_success      (o_success),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 4 ns period, 2 ns high and 2 ns low
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer predictor: own copy of the control state and registers
    // ------------------------------------------------------------------
    t_seq_phase     seq_phase   = SEQ_IDLE;
    logic           seq_is_read = 1'b0;
    logic [15:0]    seq_target  = '0;
    logic [7:0]     payload_mem [PAYLOAD_DEPTH];
    logic [PCW-1:0] payload_len = '0;
    logic [PCW-1:0] seq_pos     = '0;
    logic [6:0]     dev_sel     = DEVICE_SELECT_RESET;
    logic [4:0]     rd_count    = READ_COUNT_RESET;

    t_result results_due [$];
    t_row    stim_rows [$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;
    int      idle_cycles = 0;

    // Bytes per read, held within 1..16
    function automatic logic [4:0] read_len();
        if (rd_count < 5'd1)
            return 5'd1;
        if (rd_count > READ_COUNT_MAX)
            return READ_COUNT_MAX;
        return rd_count;
    endfunction

    // Advance the predictor by one item; return 1 when a result is due
    function automatic logic sequence_step(input t_item it, output t_result r);
        logic bad;
        bad = 1'b0;
        r   = '0;
        if (it.kind == KIND_LOAD) begin
            if (seq_phase != SEQ_IDLE)
                return 1'b0;
            // Drop bytes beyond the store; the length saturates with the position
            if (seq_pos < PAYLOAD_DEPTH) begin
                payload_mem[seq_pos[PAW-1:0]] = it.payload_byte;
                seq_pos = seq_pos + 1'b1;
            end
            if (it.payload_last) begin
                payload_len = seq_pos;
                seq_pos     = '0;
            end
            return 1'b0;
        end
        if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
            if (seq_phase != SEQ_IDLE)
                return 1'b0;
            // A request abandons any partial load
            seq_is_read = (it.kind == KIND_READ);
            seq_target  = it.mem_address;
            seq_pos     = '0;
            seq_phase   = SEQ_START;
            r.cmd       = CMD_START;
            return 1'b1;
        end
        case (seq_phase)
            SEQ_IDLE: return 1'b0;
            SEQ_START, SEQ_RETRY: begin
                // A retried START may come back as a repeated start
                if (it.bus_status != ST_START &&
                    !(seq_phase == SEQ_RETRY && it.bus_status == ST_RESTART)) begin
                    bad = 1'b1;
                end else begin
                    seq_phase = SEQ_SLAW;
                    r.cmd     = CMD_TX;
                    r.tx_byte = {dev_sel, 1'b0};
                end
            end
            SEQ_SLAW: begin
                if (it.bus_status != ST_SLAW_ACK) begin
                    seq_phase = SEQ_RETRY;
                    r.cmd     = CMD_START;
                end else begin
                    seq_phase = SEQ_ADDR_HI;
                    r.cmd     = CMD_TX;
                    r.tx_byte = seq_target[15:8];
                end
            end
            SEQ_ADDR_HI: begin
                if (it.bus_status != ST_DATA_ACK) begin
                    bad = 1'b1;
                end else begin
                    seq_phase = SEQ_ADDR_LO;
                    r.cmd     = CMD_TX;
                    r.tx_byte = seq_target[7:0];
                end
            end
            SEQ_ADDR_LO, SEQ_DATA: begin
                if (it.bus_status != ST_DATA_ACK) begin
                    bad = 1'b1;
                end else if (seq_phase == SEQ_ADDR_LO && seq_is_read) begin
                    seq_phase = SEQ_RESTART;
                    r.cmd     = CMD_START;
                end else begin
                    if (seq_phase == SEQ_ADDR_LO)
                        seq_pos = '0;
                    if (seq_pos < payload_len && seq_pos < PAYLOAD_DEPTH) begin
                        seq_phase = SEQ_DATA;
                        r.cmd     = CMD_TX;
                        r.tx_byte = payload_mem[seq_pos[PAW-1:0]];
                        seq_pos   = seq_pos + 1'b1;
                    end else begin
                        // Payload exhausted (or empty): close with STOP
                        seq_phase = SEQ_IDLE;
                        seq_pos   = '0;
                        r.cmd     = CMD_STOP;
                        r.done    = 1'b1;
                        r.success = 1'b1;
                    end
                end
            end
            SEQ_RESTART: begin
                if (it.bus_status != ST_RESTART) begin
                    bad = 1'b1;
                end else begin
                    seq_phase = SEQ_SLAR;
                    r.cmd     = CMD_TX;
                    r.tx_byte = {dev_sel, 1'b1};
                end
            end
            SEQ_SLAR: begin
                if (it.bus_status != ST_SLAR_ACK) begin
                    bad = 1'b1;
                end else begin
                    seq_phase = SEQ_RX;
                    seq_pos   = '0;
                    r.cmd     = (read_len() <= 5'd1) ? CMD_RX_NACK : CMD_RX_ACK;
                end
            end
            default: begin
                if (seq_pos + 1'b1 >= read_len()) begin
                    // Last byte: hand it over together with STOP
                    if (it.bus_status != ST_RX_NACK) begin
                        bad = 1'b1;
                    end else begin
                        r.cmd      = CMD_STOP;
                        r.rx_valid = 1'b1;
                        r.rx_data  = it.rx_byte;
                        r.rx_index = seq_pos[3:0];
                        r.done     = 1'b1;
                        r.success  = 1'b1;
                        seq_phase  = SEQ_IDLE;
                        seq_pos    = '0;
                    end
                end else if (it.bus_status != ST_RX_ACK) begin
                    bad = 1'b1;
                end else begin
                    r.rx_valid = 1'b1;
                    r.rx_data  = it.rx_byte;
                    r.rx_index = seq_pos[3:0];
                    seq_pos    = seq_pos + 1'b1;
                    r.cmd      = (seq_pos + 1'b1 >= read_len()) ? CMD_RX_NACK : CMD_RX_ACK;
                end
            end
        endcase
        if (bad) begin
            // Unexpected status: end at once, no STOP
            r         = '0;
            r.done    = 1'b1;
            seq_phase = SEQ_IDLE;
            seq_pos   = '0;
        end
        return 1'b1;
    endfunction

    // Status that keeps the current transaction on its normal path
    function automatic logic [4:0] wanted_status();
        case (seq_phase)
            SEQ_START:   return ST_START;
            SEQ_RETRY:   return $urandom_range(1) ? ST_START : ST_RESTART;
            SEQ_SLAW:    return ($urandom_range(3) == 0) ? ST_SLAW_NACK : ST_SLAW_ACK;
            SEQ_RESTART: return ST_RESTART;
            SEQ_SLAR:    return ST_SLAR_ACK;
            SEQ_RX:      return (seq_pos + 1'b1 >= read_len()) ? ST_RX_NACK : ST_RX_ACK;
            default:     return ST_DATA_ACK;
        endcase
    endfunction

    function automatic t_item random_item(input t_kind k);
        t_item it;
        it.kind         = k;
        it.mem_address  = 16'($urandom_range(16'hFFFF));
        it.payload_byte = 8'($urandom_range(8'hFF));
        it.payload_last = 1'($urandom_range(1));
        it.bus_status   = 5'($urandom_range(31));
        it.rx_byte      = 8'($urandom_range(8'hFF));
        return it;
    endfunction

    function automatic t_result mk_res(input t_cmd cmd, input logic [7:0] tx,
                                       input logic rxv, input logic [7:0] rxd,
                                       input logic [3:0] rxi, input logic done,
                                       input logic ok);
        t_result r;
        r.cmd      = cmd;
        r.tx_byte  = tx;
        r.rx_valid = rxv;
        r.rx_data  = rxd;
        r.rx_index = rxi;
        r.done     = done;
        r.success  = ok;
        return r;
    endfunction

    function automatic void add_item(input t_kind k, input logic [15:0] addr,
                                     input logic [7:0] pbyte, input logic plast,
                                     input logic [4:0] st, input logic [7:0] rx,
                                     input t_exp_src src, input t_result res);
        t_row row;
        row      = '0;
        row.op   = ROW_ITEM;
        row.item = '{k, addr, pbyte, plast, st, rx};
        row.src  = src;
        row.res  = res;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [6:0] val);
        t_row row;
        row           = '0;
        row.op        = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_value = val;
        stim_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one item, hold it until accepted, then book its expectation
    task automatic send_item(input t_item it, input t_exp_src src, input t_result typed);
        t_result r;
        logic    has;
        logic    ignored;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= it.kind;
        i_mem_address  <= it.mem_address;
        i_payload_byte <= it.payload_byte;
        i_payload_last <= it.payload_last;
        i_bus_status   <= it.bus_status;
        i_rx_byte      <= it.rx_byte;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ignored = (it.kind == KIND_EVENT) ? (seq_phase == SEQ_IDLE) : (seq_phase != SEQ_IDLE);
        has = sequence_step(it, r);
        case (src)
            EXP_MODEL: if (has) results_due.push_back(r);
            EXP_TYPED: results_due.push_back(typed);
            default: ;
        endcase
        if (!ignored)
            items_sent++;
    endtask

    // Drain the block, let a trailing no-result item settle, then write
    task automatic write_register(input logic idx, input logic [6:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_DEVICE_SELECT)
            dev_sel = val;
        else
            rd_count = val[4:0];
        i_cfg_valid <= 1'b0;
    endtask

    // One transaction from idle back to idle, with some noise mixed in
    task automatic run_transaction();
        t_item it;
        int    n;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            // Mostly short payloads; now and then a long one that may overflow the store
            n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                it = random_item(KIND_LOAD);
                // Leave the odd load unterminated so the request abandons it
                it.payload_last = (i == n - 1) && ($urandom_range(9) != 0);
                send_item(it, EXP_MODEL, '0);
            end
            send_item(random_item(KIND_WRITE), EXP_MODEL, '0);
        end else if (pick < 85) begin
            send_item(random_item(KIND_READ), EXP_MODEL, '0);
        end else begin
            // Noise in idle: a stray bus event or a lone load
            send_item(random_item($urandom_range(1) ? KIND_EVENT : KIND_LOAD), EXP_MODEL, '0);
        end
        while (seq_phase != SEQ_IDLE) begin
            if ($urandom_range(99) < 4) begin
                // Request or load while busy: must be ignored
                it = random_item(t_kind'($urandom_range(1, 3)));
            end else begin
                it = random_item(KIND_EVENT);
                if ($urandom_range(99) >= 3)
                    it.bus_status = wanted_status();
            end
            send_item(it, EXP_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, result check, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $error("result with nothing expected: command %0d", o_command);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("command",  want.cmd,      o_command);
                check_field("tx_byte",  want.tx_byte,  o_tx_byte);
                check_field("rx_valid", want.rx_valid, o_rx_valid);
                check_field("rx_data",  want.rx_data,  o_rx_data);
                check_field("rx_index", want.rx_index, o_rx_index);
                check_field("done_res", want.done,     o_done_res);
                check_field("success",  want.success,  o_success);
            end
        end
    end

    // Count cycles without any handshake; give up once the limit is reached
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int base;
        int dev;
        int cnt;

        // Directed rows. Registers at reset: device 80, read count 10.
        // Bus event with nothing running: ignore
        add_item(KIND_EVENT, 16'hFFFF, 8'hFF, 1'b1, ST_START, 8'hFF, EXP_NONE, '0);
        // Write before any load: empty payload, STOP right after the address
        add_item(KIND_WRITE, 16'h0000, 8'h00, 1'b0, 5'd0, 8'h00, EXP_TYPED,
                 mk_res(CMD_START, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_START, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, {DEVICE_SELECT_RESET, 1'b0}, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_SLAW_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_STOP, 8'h00, 1'b0, 8'h00, 4'd0, 1'b1, 1'b1));
        // Two-byte payload at the byte extremes
        add_item(KIND_LOAD, 16'h0000, 8'h00, 1'b0, 5'd0, 8'h00, EXP_NONE, '0);
        add_item(KIND_LOAD, 16'hFFFF, 8'hFF, 1'b1, 5'd0, 8'h00, EXP_NONE, '0);
        add_item(KIND_WRITE, 16'hFFFF, 8'h00, 1'b0, 5'd0, 8'h00, EXP_TYPED,
                 mk_res(CMD_START, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_START, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, {DEVICE_SELECT_RESET, 1'b0}, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        // SLA+W not acknowledged: new START, answered by a repeated start
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, 5'd0, 8'h00, EXP_TYPED,
                 mk_res(CMD_START, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_RESTART, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, {DEVICE_SELECT_RESET, 1'b0}, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        // Request while busy: ignore
        add_item(KIND_READ, 16'hFFFF, 8'hFF, 1'b1, 5'd31, 8'hFF, EXP_NONE, '0);
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_SLAW_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'hFF, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'hFF, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_MODEL, '0);
        // Load while busy: ignore
        add_item(KIND_LOAD, 16'h0000, 8'h5A, 1'b1, 5'd0, 8'h00, EXP_NONE, '0);
        // Unexpected status mid-payload: fail, no STOP
        add_item(KIND_EVENT, 16'hFFFF, 8'hFF, 1'b1, 5'd31, 8'hFF, EXP_TYPED,
                 mk_res(CMD_NONE, 8'h00, 1'b0, 8'h00, 4'd0, 1'b1, 1'b0));
        // Single-byte read from the top device address
        add_cfg(CFG_READ_COUNT, 7'd1);
        add_cfg(CFG_DEVICE_SELECT, 7'h7F);
        // Partial load, abandoned by the request that follows
        add_item(KIND_LOAD, 16'h0000, 8'hAB, 1'b0, 5'd0, 8'h00, EXP_NONE, '0);
        add_item(KIND_READ, 16'h1234, 8'h00, 1'b0, 5'd0, 8'h00, EXP_TYPED,
                 mk_res(CMD_START, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_START, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, {7'h7F, 1'b0}, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_SLAW_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'h12, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, 8'h34, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        // Low address byte taken: repeated START for the read
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_DATA_ACK, 8'h00, EXP_TYPED,
                 mk_res(CMD_START, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_RESTART, 8'h00, EXP_TYPED,
                 mk_res(CMD_TX, {7'h7F, 1'b1}, 1'b0, 8'h00, 4'd0, 1'b0, 1'b0));
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_SLAR_ACK, 8'h00, EXP_MODEL, '0);
        // Last read byte: data and STOP in one result
        add_item(KIND_EVENT, 16'h0000, 8'h00, 1'b0, ST_RX_NACK, 8'hFF, EXP_TYPED,
                 mk_res(CMD_STOP, 8'h00, 1'b1, 8'hFF, 4'd0, 1'b1, 1'b1));

        // Hold reset, then release it for good
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].op == ROW_CFG)
                write_register(stim_rows[i].cfg_index, stim_rows[i].cfg_value);
            else
                send_item(stim_rows[i].item, stim_rows[i].src, stim_rows[i].res);
        end

        // Random phases: new register settings each, idling pattern rotating
        base = items_sent;
        for (int p = 0; p < 8; p++) begin
            dev = (p == 0) ? 0 : (p == 1) ? 127 : $urandom_range(127);
            cnt = (p == 0) ? 16 : (p == 1) ? 1 : (p == 2) ? 2 : $urandom_range(1, 16);
            write_register(CFG_DEVICE_SELECT, dev[6:0]);
            write_register(CFG_READ_COUNT, cnt[6:0]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            while (items_sent < base + (p + 1) * ITEMS_PER_PHASE)
                run_transaction();
        end

        // Drop valid, wait for the last results, then allow a little slack
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
